[hw/rtl/sli_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list package
// Shared types, codes and default sizes for the sorted insertion list.
// ----------------------------------------------------------------------------
package sli_pkg;

   // Default sizes for the top-level parameters.
   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths of the request and response transactions.
   localparam int MODE_W  = 2;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int TOTAL_W = 5;

   // Request operation codes.
   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT     = 2'd0,
      MODE_READ_FIRST = 2'd1,
      MODE_READ_NEXT  = 2'd2,
      MODE_CLEAR      = 2'd3
   } mode_type;

   // Response status codes.
   typedef enum logic [STAT_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_END  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // Request transaction payload.
   typedef struct packed {
      mode_type                   mode;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic signed [VALUE_W-1:0]  read_value;
      status_type                 status;
      logic [TOTAL_W-1:0]         entry_total;
   } rsp_type;

endpackage
`default_nettype wire

[hw/rtl/sli_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list entry memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sli_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/sli_cmp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list comparator
// Decides whether a new value passes a stored entry under the current order.
// ----------------------------------------------------------------------------
module sli_cmp #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic signed [DATA_WIDTH-1:0] new_value,
   input  wire logic signed [DATA_WIDTH-1:0] entry_value,
   input  wire logic                         ascending,
   output logic                              passes
);

   // In ascending order a value passes smaller entries, in descending order
   // it passes larger ones. Equal entries are never passed.
   always_comb begin
      if (ascending) begin
         passes = (new_value > entry_value);
      end else begin
         passes = (new_value < entry_value);
      end
   end

endmodule
`default_nettype wire

[hw/rtl/sorted_list_insert_readout_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted insertion list, top level
// An insert holds busy through the scan, shift and write states it needs, a read
// through its read state; each registers its response as busy falls. Clear,
// refused inserts and empty or end-of-list reads respond the cycle after
// acceptance with no busy. A new request is taken only while idle; responses
// cannot stall.
// Reset (synchronous) empties the list, drops the cursor, selects descending.
// ----------------------------------------------------------------------------
module sorted_list_insert_readout_unit
   import sli_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_data,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_SHIFT = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_READ  = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              pos_ff, pos_in;
   logic                          cursor_ff, cursor_in;
   logic                          asc_ff;
   logic signed [DATA_WIDTH-1:0]  new_ff, new_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [IDX_W-1:0]              ins_ff, ins_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_ff, rsp_in;

   logic                          mem_rd_en;
   logic [IDX_W-1:0]              mem_rd_addr;
   logic [DATA_WIDTH-1:0]         mem_rd_data;
   logic                          mem_wr_en;
   logic [IDX_W-1:0]              mem_wr_addr;
   logic [DATA_WIDTH-1:0]         mem_wr_data;
   logic signed [DATA_WIDTH-1:0]  rd_signed;
   logic                          cmp_passes;
   logic [CNT_W-1:0]              pos_next;
   logic [CNT_W-1:0]              idx_next;

   // Entry storage.
   sli_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign rd_signed = $signed(mem_rd_data);

   // Comparator, fed by the memory read data during the scan.
   sli_cmp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_cmp (
      .new_value   (new_ff),
      .entry_value (rd_signed),
      .ascending   (asc_ff),
      .passes      (cmp_passes)
   );

   assign pos_next = CNT_W'(pos_ff) + CNT_W'(1);
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);

   // Sequencer: an insert scans front to back, shifts back to front, then writes; also reads and clear.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cursor_in    = cursor_ff;
      new_in       = new_ff;
      idx_in       = idx_ff;
      ins_in       = ins_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rsp_in.read_value = '0;
      rsp_in.status     = STATUS_OK;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = new_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.mode)
                  MODE_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        new_in    = DATA_WIDTH'(req_data.value);
                        cursor_in = 1'b0;
                        idx_in    = '0;
                        ins_in    = '0;
                        if (count_ff == '0) begin
                           state_in = ST_WRITE;
                        end else begin
                           mem_rd_en   = 1'b1;
                           mem_rd_addr = '0;
                           state_in    = ST_SCAN;
                        end
                     end
                  end
                  MODE_READ_FIRST: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_END;
                        cursor_in     = 1'b0;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        pos_in      = '0;
                        cursor_in   = 1'b1;
                        state_in    = ST_READ;
                     end
                  end
                  MODE_READ_NEXT: begin
                     if (!cursor_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_END;
                     end else if (pos_next >= count_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_END;
                        cursor_in     = 1'b0;
                     end else begin
                        pos_in      = IDX_W'(pos_next);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = IDX_W'(pos_next);
                        state_in    = ST_READ;
                     end
                  end
                  MODE_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                     pos_in       = '0;
                     cursor_in    = 1'b0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // The entry at idx_ff is on the read data; stop at the first one
         // that the new value does not pass.
         ST_SCAN: begin
            if (cmp_passes) begin
               if (idx_next == count_ff) begin
                  ins_in   = IDX_W'(idx_next);
                  state_in = ST_WRITE;
               end else begin
                  idx_in      = IDX_W'(idx_next);
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = IDX_W'(idx_next);
               end
            end else begin
               ins_in      = idx_ff;
               idx_in      = IDX_W'(count_ff - CNT_W'(1));
               mem_rd_en   = 1'b1;
               mem_rd_addr = IDX_W'(count_ff - CNT_W'(1));
               state_in    = ST_SHIFT;
            end
         end

         // Move the entry at idx_ff one place back while reading the one before.
         ST_SHIFT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff + IDX_W'(1);
            mem_wr_data = mem_rd_data;
            if (idx_ff == ins_ff) begin
               state_in = ST_WRITE;
            end else begin
               idx_in      = idx_ff - IDX_W'(1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff - IDX_W'(1);
            end
         end

         // Place the new value and report the transaction.
         ST_WRITE: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = ins_ff;
            mem_wr_data  = new_ff;
            count_in     = count_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         // Report the entry at the cursor.
         ST_READ: begin
            rsp_valid_in      = 1'b1;
            rsp_in.read_value = VALUE_W'(rd_signed);
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.entry_total = TOTAL_W'(count_in);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         cursor_ff    <= 1'b0;
         asc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            asc_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      new_ff <= new_in;
      idx_ff <= idx_in;
      ins_ff <= ins_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Sorted insertion list testbench
// Drives insert, read-first, read-next and clear transactions into the list
// and checks every response against a cycle-free prediction of the list
// contents, count and read cursor, under both sort orders.
// ----------------------------------------------------------------------------
module tb_top
   import sli_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH   = CAPACITY_DEF;
   localparam int SETTLE_TICKS = 4;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_TICKS   = 40;
   localparam int PRINT_LIMIT  = 100;

   // One queued stimulus step: either a request transaction or a register write.
   typedef struct {
      bit          is_cfg;
      req_type     req;
      logic        cfg_bit;
      int unsigned gap;
   } pending_op_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   req_type req_data    = '0;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   pending_op_type pending_ops[$];
   rsp_type        expected_rsps[$];

   // Predicted list state.
   logic signed [VALUE_W-1:0] shadow_list[LIST_DEPTH];
   int   stored_total = 0;
   int   cursor_pos   = 0;
   bit   cursor_ok    = 1'b0;
   bit   order_up     = 1'b0;

   logic req_taken  = 1'b0;
   int   idle_run   = 0;
   bit   no_idle    = 1'b0;
   int   queued_items = 0;

   int   mismatch_count = 0;
   int   items_done     = 0;
   int   inserts_ok     = 0;
   int   inserts_full   = 0;
   int   reads_ok       = 0;
   int   reads_end      = 0;
   int   clears_done    = 0;
   int   cfg_writes     = 0;
   int   peak_total     = 0;

   sorted_list_insert_readout_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_data    (req_data),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Clock generation, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Computes the response to one request and advances the predicted list.
   function automatic rsp_type predict_response(req_type r);
      rsp_type res;
      int      slot;
      int      i;
      res.read_value  = '0;
      res.status      = STATUS_OK;
      case (r.mode)
         MODE_INSERT: begin
            if (stored_total >= LIST_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               // Walk past every entry the new value passes in the current order.
               slot = 0;
               while (slot < stored_total &&
                      (order_up ? (r.value > shadow_list[slot])
                                : (r.value < shadow_list[slot])))
                  slot++;
               for (i = stored_total; i > slot; i--)
                  shadow_list[i] = shadow_list[i-1];
               shadow_list[slot] = r.value;
               stored_total++;
               cursor_ok = 1'b0;
            end
         end
         MODE_READ_FIRST: begin
            if (stored_total == 0) begin
               res.status = STATUS_END;
               cursor_ok  = 1'b0;
            end else begin
               cursor_pos     = 0;
               cursor_ok      = 1'b1;
               res.read_value = shadow_list[0];
            end
         end
         MODE_READ_NEXT: begin
            if (!cursor_ok) begin
               res.status = STATUS_END;
            end else if (cursor_pos + 1 >= stored_total || cursor_pos + 1 >= LIST_DEPTH) begin
               res.status = STATUS_END;
               cursor_ok  = 1'b0;
            end else begin
               cursor_pos++;
               res.read_value = shadow_list[cursor_pos];
            end
         end
         default: begin
            stored_total = 0;
            cursor_pos   = 0;
            cursor_ok    = 1'b0;
         end
      endcase
      res.entry_total = TOTAL_W'(stored_total);
      return res;
   endfunction

   // Prints one mismatch line (up to a limit) and counts it.
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] mismatch, %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2, 3, 4: return $urandom_range(0, 8) - 32'd4;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_item(mode_type m, logic [31:0] v);
      pending_op_type op;
      op.is_cfg    = 1'b0;
      op.req.mode  = m;
      op.req.value = v;
      op.cfg_bit   = 1'b0;
      op.gap       = (no_idle || $urandom_range(0, 99) >= 30) ? 0 : $urandom_range(1, 10);
      pending_ops.push_back(op);
      queued_items++;
   endtask

   task automatic push_cfg(logic b);
      pending_op_type op;
      op.is_cfg  = 1'b1;
      op.req     = '0;
      op.cfg_bit = b;
      op.gap     = 0;
      pending_ops.push_back(op);
   endtask

   // A well-formed sequence: optional clear, inserts, then a read-out walk with rare inserts.
   task automatic queue_burst();
      int n_ins;
      int n_next;
      if ($urandom_range(0, 99) < 30)
         push_item(MODE_CLEAR, $urandom);
      n_ins = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
      repeat (n_ins) push_item(MODE_INSERT, pick_value());
      push_item(MODE_READ_FIRST, $urandom);
      n_next = $urandom_range(0, 18);
      repeat (n_next) begin
         if ($urandom_range(0, 19) == 0)
            push_item(MODE_INSERT, pick_value());
         push_item(MODE_READ_NEXT, $urandom);
      end
      // Occasional noise of arbitrary operations.
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 6)) push_item(mode_type'($urandom_range(0, 3)), $urandom);
   endtask

   // Driver: presents queued transactions and register writes at the falling edge.
   always @(negedge clock) begin : drive
      logic    nxt_start;
      logic    nxt_wr;
      req_type nxt_req;
      nxt_start = start;
      nxt_wr    = 1'b0;
      nxt_req   = req_data;
      if (reset) begin
         nxt_start = 1'b0;
      end else begin
         if (start && req_taken)
            nxt_start = 1'b0;
         if (!nxt_start && pending_ops.size() != 0) begin
            if (pending_ops[0].is_cfg) begin
               // Register writes wait until the list has gone quiet.
               if (expected_rsps.size() == 0 && idle_run >= SETTLE_TICKS && !csr_wr_en) begin
                  nxt_wr = 1'b1;
                  csr_wr_data <= pending_ops[0].cfg_bit;
                  void'(pending_ops.pop_front());
               end
            end else if (pending_ops[0].gap != 0) begin
               pending_ops[0].gap--;
            end else begin
               nxt_start = 1'b1;
               nxt_req   = pending_ops[0].req;
               void'(pending_ops.pop_front());
            end
         end
      end
      // Idle cycles carry random junk on the request bus.
      if (!nxt_start)
         nxt_req = {mode_type'($urandom_range(0, 3)), 32'($urandom)};
      start     <= nxt_start;
      req_data  <= nxt_req;
      csr_wr_en <= nxt_wr;
   end

   // Monitor: checks responses, predicts accepted requests, tracks idleness.
   always @(posedge clock) begin : observe
      rsp_type want;
      if (rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with none expected", rsp_data.read_value, 32'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.read_value !== want.read_value)
               report_mismatch("read_value", rsp_data.read_value, want.read_value);
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.entry_total !== want.entry_total)
               report_mismatch("entry_total", 32'(rsp_data.entry_total), 32'(want.entry_total));
         end
      end
      if (csr_wr_en) begin
         order_up = csr_wr_data;
         cfg_writes++;
      end
      if (!reset && start && !busy) begin
         want = predict_response(req_data);
         expected_rsps.push_back(want);
         items_done++;
         if (stored_total > peak_total)
            peak_total = stored_total;
         case (req_data.mode)
            MODE_INSERT:  if (want.status == STATUS_FULL) inserts_full++; else inserts_ok++;
            MODE_CLEAR:   clears_done++;
            default:      if (want.status == STATUS_OK) reads_ok++; else reads_end++;
         endcase
      end
      req_taken <= !reset && start && !busy;
      if (expected_rsps.size() == 0 && !busy && !start && !rsp_valid)
         idle_run++;
      else
         idle_run = 0;
   end

   // Watchdog: ends the run if nothing moves for too long.
   always @(posedge clock) begin : watchdog
      int stall_ticks;
      if ((start && !busy) || rsp_valid || csr_wr_en || reset)
         stall_ticks = 0;
      else
         stall_ticks++;
      if (stall_ticks >= STALL_LIMIT) begin
         $display("timeout after %0d cycles without a transaction", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      int phase;
      int phase_end;
      foreach (shadow_list[k])
         shadow_list[k] = '0;

      // Directed part, descending order.
      push_cfg(1'b0);
      push_item(MODE_READ_FIRST, 32'd0);
      push_item(MODE_READ_NEXT, 32'hffff_ffff);
      push_item(MODE_INSERT, 32'd5);
      push_item(MODE_INSERT, 32'h7fff_ffff);
      push_item(MODE_INSERT, 32'h8000_0000);
      push_item(MODE_INSERT, 32'd5);
      push_item(MODE_INSERT, 32'hffff_ffff);
      push_item(MODE_INSERT, 32'd0);
      push_item(MODE_READ_FIRST, 32'd0);
      repeat (6) push_item(MODE_READ_NEXT, 32'd0);
      push_item(MODE_INSERT, 32'd3);
      push_item(MODE_READ_NEXT, 32'd0);
      push_item(MODE_CLEAR, 32'd0);
      push_item(MODE_READ_FIRST, 32'd0);

      // Directed part, ascending order; the list keeps its entries afterward.
      push_cfg(1'b1);
      push_item(MODE_INSERT, 32'h7fff_ffff);
      push_item(MODE_INSERT, 32'h8000_0000);
      push_item(MODE_INSERT, 32'd0);
      push_item(MODE_READ_FIRST, 32'd0);
      repeat (3) push_item(MODE_READ_NEXT, 32'd0);

      // Random phases; the order flips each phase without clearing the list.
      phase = 0;
      while (queued_items < 920) begin
         no_idle = (phase == 3);
         push_cfg(phase[0]);
         phase_end = queued_items + 110;
         while (queued_items < phase_end)
            queue_burst();
         phase++;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || expected_rsps.size() != 0 || start)
         @(posedge clock);
      repeat (TAIL_TICKS) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch("responses never arrived", expected_rsps.size(), 32'd0);

      $display("covered %0d transactions: %0d inserts, %0d refused as full, %0d clears",
               items_done, inserts_ok, inserts_full, clears_done);
      $display("reads: %0d with data, %0d at end of list; %0d order writes, peak count %0d",
               reads_ok, reads_end, cfg_writes, peak_total);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
